@@ hw/rtl/tblru_pkg.sv @@
`timescale 1ns / 1ps
package tblru_pkg;

   typedef enum logic [1:0] {
      OP_LOOKUP      = 2'd0,
      OP_INSERT      = 2'd1,
      OP_INVAL_RANGE = 2'd2,
      OP_INVAL_ALL   = 2'd3
   } opcode_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] address;
      logic [31:0] size;
      logic [31:0] handle;
      logic [63:0] stamp;
   } entry_type;

   typedef struct packed {
      logic start;
      logic sample;
   } scan_ctl_type;

   localparam logic [6:0] MAX_ENTRIES_RESET = 7'd64;
   localparam int unsigned CSR_MAX_ENTRIES = 0;

endpackage

@@ hw/rtl/translated_block_lru_table_core.sv @@
`timescale 1ns / 1ps
// channel   direction  transfer when            payload
// req_      in         req_valid & req_ready    opcode, address, block_size, entry_handle,
//                                               range_length
// rsp_      out        rsp_valid & rsp_ready    hit, found_size, found_handle, evicted,
//                                               evicted_address, removed_count
// csr       in/out     psel & penable & pwrite  max_entries at byte address 0
//
// Each item runs from transfer to the next free input slot through these steps: one
// read of the entry memory per entry, one drain, decide, two write-back slots, result.
// After reset a clearing pass writes every entry invalid, with req_ready low.
// A held result stalls only the completion of the following item.
module translated_block_lru_table_core #(
   parameter int unsigned ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_address,
   input  logic [31:0] req_block_size,
   input  logic [31:0] req_entry_handle,
   input  logic [31:0] req_range_length,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_hit,
   output logic [31:0] rsp_found_size,
   output logic [31:0] rsp_found_handle,
   output logic        rsp_evicted,
   output logic [31:0] rsp_evicted_address,
   output logic [6:0]  rsp_removed_count,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import tblru_pkg::*;

   localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CW = $clog2(ENTRIES + 1);
   localparam int unsigned LW = CW + 7;

   typedef enum logic [7:0] {
      ST_INIT     = 8'b0000_0001,
      ST_IDLE     = 8'b0000_0010,
      ST_SCAN     = 8'b0000_0100,
      ST_DRAIN    = 8'b0000_1000,
      ST_DECIDE   = 8'b0001_0000,
      ST_WB_EVICT = 8'b0010_0000,
      ST_WB_FILL  = 8'b0100_0000,
      ST_DONE     = 8'b1000_0000
   } state_type;

   state_type     state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          idx_last;
   logic          smp_ff;
   logic [IW-1:0] smp_idx_ff;
   logic [6:0]    max_ff;
   logic [63:0]   ctr_ff;
   logic          csr_sel, csr_wr;

   opcode_type    op_ff;
   logic [31:0]   key_ff, size_ff, handle_ff, end_ff;
   logic          nz_ff;

   entry_type     rd_data, wr_data, wb_data_ff;
   logic          wr_en;
   logic [IW-1:0] wr_idx;

   scan_ctl_type  scan_ctl;
   logic          drop, match, free, oldest;
   logic [CW-1:0] valid_cnt, removed_cnt;
   logic [IW-1:0] match_idx, free_idx, oldest_idx;
   logic [31:0]   match_size, match_handle, oldest_address;

   logic [LW-1:0] lim, cnt_w, max_w;
   logic          ev_need, do_ev;
   logic [IW-1:0] fill_idx;
   logic          ev_wr_ff, fill_wr_ff;
   logic [IW-1:0] ev_idx_ff, fill_idx_ff;

   logic          res_hit_ff, res_ev_ff;
   logic [31:0]   res_size_ff, res_handle_ff, res_evaddr_ff;
   logic [6:0]    res_rm_ff;
   logic [CW+6:0] rm_wide;

   logic          rsp_valid_ff;
   logic          rsp_hit_ff, rsp_ev_ff;
   logic [31:0]   rsp_size_ff, rsp_handle_ff, rsp_evaddr_ff;
   logic [6:0]    rsp_rm_ff;

   logic          accept, rsp_load;

   assign pready  = 1'b1;
   assign csr_sel = (paddr[2] == 1'b0);
   assign csr_wr  = psel && penable && pwrite && csr_sel;
   assign prdata  = csr_sel ? {25'd0, max_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MAX_ENTRIES_RESET;
      end else if (csr_wr) begin
         max_ff <= pwdata[6:0];
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign idx_last  = (idx_ff == IW'(ENTRIES - 1));
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         ST_INIT: begin
            idx_in = idx_ff + IW'(1);
            if (idx_last) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + IW'(1);
            if (idx_last) begin
               idx_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:    state_in = ST_DECIDE;
         ST_DECIDE:   state_in = ST_WB_EVICT;
         ST_WB_EVICT: state_in = ST_WB_FILL;
         ST_WB_FILL:  state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
            idx_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         idx_ff   <= '0;
         smp_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         smp_ff   <= (state_ff == ST_SCAN);
      end
   end

   always_ff @(posedge clock) begin
      smp_idx_ff <= idx_ff;
      if (accept) begin
         op_ff     <= opcode_type'(req_opcode);
         key_ff    <= req_address;
         size_ff   <= req_block_size;
         handle_ff <= req_entry_handle;
         end_ff    <= req_address + req_range_length;
         nz_ff     <= (req_range_length != 32'd0);
      end
   end

   assign scan_ctl.start  = accept;
   assign scan_ctl.sample = smp_ff;

   tblru_mem #(
      .ENTRIES (ENTRIES),
      .IW      (IW)
   ) u_mem (
      .clock   (clock),
      .rd_en   (state_ff == ST_SCAN),
      .rd_idx  (idx_ff),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_idx  (wr_idx),
      .wr_data (wr_data)
   );

   tblru_scan #(
      .IW (IW),
      .CW (CW)
   ) u_scan (
      .clock          (clock),
      .ctl            (scan_ctl),
      .op             (op_ff),
      .key            (key_ff),
      .range_end      (end_ff),
      .range_nz       (nz_ff),
      .smp_idx        (smp_idx_ff),
      .smp_data       (rd_data),
      .drop           (drop),
      .valid_cnt      (valid_cnt),
      .removed_cnt    (removed_cnt),
      .match          (match),
      .match_idx      (match_idx),
      .match_size     (match_size),
      .match_handle   (match_handle),
      .free           (free),
      .free_idx       (free_idx),
      .oldest         (oldest),
      .oldest_idx     (oldest_idx),
      .oldest_address (oldest_address)
   );

   always_comb begin
      wr_en   = 1'b0;
      wr_idx  = idx_ff;
      wr_data = '0;
      case (state_ff)
         ST_INIT: begin
            wr_en = 1'b1;
         end
         ST_SCAN, ST_DRAIN: begin
            wr_en         = smp_ff && drop;
            wr_idx        = smp_idx_ff;
            wr_data       = rd_data;
            wr_data.valid = 1'b0;
         end
         ST_WB_EVICT: begin
            wr_en  = ev_wr_ff;
            wr_idx = ev_idx_ff;
         end
         ST_WB_FILL: begin
            wr_en   = fill_wr_ff;
            wr_idx  = fill_idx_ff;
            wr_data = wb_data_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   assign max_w = {{CW{1'b0}}, max_ff};
   assign cnt_w = {7'd0, valid_cnt};

   always_comb begin
      if (max_w == '0) begin
         lim = LW'(1);
      end else if (max_w > LW'(ENTRIES)) begin
         lim = LW'(ENTRIES);
      end else begin
         lim = max_w;
      end
   end

   assign ev_need = match ? (cnt_w > lim) : ((cnt_w + LW'(1)) > lim);
   assign do_ev   = ev_need && oldest;

   always_comb begin
      if (match) begin
         fill_idx = match_idx;
      end else if (!free || (do_ev && oldest_idx < free_idx)) begin
         fill_idx = oldest_idx;
      end else begin
         fill_idx = free_idx;
      end
   end

   assign rm_wide = (op_ff == OP_INVAL_ALL) ? {7'd0, valid_cnt} : {7'd0, removed_cnt};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_ff     <= 64'd0;
         ev_wr_ff   <= 1'b0;
         fill_wr_ff <= 1'b0;
      end else if (state_ff == ST_DECIDE) begin
         ev_wr_ff   <= 1'b0;
         fill_wr_ff <= 1'b0;
         case (op_ff)
            OP_LOOKUP: begin
               fill_wr_ff <= match;
               if (match) begin
                  ctr_ff <= ctr_ff + 64'd1;
               end
            end
            OP_INSERT: begin
               ctr_ff     <= ctr_ff + 64'd1;
               fill_wr_ff <= 1'b1;
               ev_wr_ff   <= do_ev && (fill_idx != oldest_idx);
            end
            default: begin
               ev_wr_ff <= 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DECIDE) begin
         ev_idx_ff          <= oldest_idx;
         fill_idx_ff        <= (op_ff == OP_INSERT) ? fill_idx : match_idx;
         wb_data_ff.valid   <= 1'b1;
         wb_data_ff.address <= key_ff;
         wb_data_ff.stamp   <= ctr_ff + 64'd1;
         res_hit_ff         <= 1'b0;
         res_ev_ff          <= 1'b0;
         res_size_ff        <= 32'd0;
         res_handle_ff      <= 32'd0;
         res_evaddr_ff      <= 32'd0;
         res_rm_ff          <= 7'd0;
         case (op_ff)
            OP_LOOKUP: begin
               wb_data_ff.size   <= match_size;
               wb_data_ff.handle <= match_handle;
               res_hit_ff        <= match;
               if (match) begin
                  res_size_ff   <= match_size;
                  res_handle_ff <= match_handle;
               end
            end
            OP_INSERT: begin
               wb_data_ff.size   <= size_ff;
               wb_data_ff.handle <= handle_ff;
               res_hit_ff        <= match;
               res_size_ff       <= size_ff;
               res_handle_ff     <= handle_ff;
               res_ev_ff         <= do_ev;
               if (do_ev) begin
                  res_evaddr_ff <= oldest_address;
               end
            end
            default: begin
               wb_data_ff.size   <= size_ff;
               wb_data_ff.handle <= handle_ff;
               res_rm_ff         <= rm_wide[6:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_hit_ff    <= res_hit_ff;
         rsp_size_ff   <= res_size_ff;
         rsp_handle_ff <= res_handle_ff;
         rsp_ev_ff     <= res_ev_ff;
         rsp_evaddr_ff <= res_evaddr_ff;
         rsp_rm_ff     <= res_rm_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_hit             = rsp_hit_ff;
   assign rsp_found_size      = rsp_size_ff;
   assign rsp_found_handle    = rsp_handle_ff;
   assign rsp_evicted         = rsp_ev_ff;
   assign rsp_evicted_address = rsp_evaddr_ff;
   assign rsp_removed_count   = rsp_rm_ff;

endmodule

@@ hw/rtl/tblru_mem.sv @@
`timescale 1ns / 1ps
module tblru_mem #(
   parameter int unsigned ENTRIES = 64,
   parameter int unsigned IW = 6
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [IW-1:0]         rd_idx,
   output tblru_pkg::entry_type  rd_data,
   input  logic                  wr_en,
   input  logic [IW-1:0]         wr_idx,
   input  tblru_pkg::entry_type  wr_data
);
   import tblru_pkg::*;

   entry_type store_ff [ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/tblru_scan.sv @@
`timescale 1ns / 1ps
module tblru_scan #(
   parameter int unsigned IW = 6,
   parameter int unsigned CW = 7
) (
   input  logic                    clock,
   input  tblru_pkg::scan_ctl_type ctl,
   input  tblru_pkg::opcode_type   op,
   input  logic [31:0]             key,
   input  logic [31:0]             range_end,
   input  logic                    range_nz,
   input  logic [IW-1:0]           smp_idx,
   input  tblru_pkg::entry_type    smp_data,
   output logic                    drop,
   output logic [CW-1:0]           valid_cnt,
   output logic [CW-1:0]           removed_cnt,
   output logic                    match,
   output logic [IW-1:0]           match_idx,
   output logic [31:0]             match_size,
   output logic [31:0]             match_handle,
   output logic                    free,
   output logic [IW-1:0]           free_idx,
   output logic                    oldest,
   output logic [IW-1:0]           oldest_idx,
   output logic [31:0]             oldest_address
);
   import tblru_pkg::*;

   logic [CW-1:0] cnt_ff, rm_ff;
   logic          match_ff, free_ff, old_ff;
   logic [IW-1:0] match_idx_ff, free_idx_ff, old_idx_ff;
   logic [31:0]   match_size_ff, match_handle_ff, old_addr_ff;
   logic [63:0]   old_stamp_ff;
   logic          key_eq, in_range;

   assign key_eq   = smp_data.valid && (smp_data.address == key);
   assign in_range = smp_data.valid && range_nz && (smp_data.address >= key)
                     && (smp_data.address < range_end);

   always_comb begin
      case (op)
         OP_INVAL_RANGE: drop = in_range;
         OP_INVAL_ALL:   drop = smp_data.valid;
         default:        drop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         cnt_ff   <= '0;
         rm_ff    <= '0;
         match_ff <= 1'b0;
         free_ff  <= 1'b0;
         old_ff   <= 1'b0;
      end else if (ctl.sample) begin
         if (smp_data.valid) begin
            cnt_ff <= cnt_ff + CW'(1);
         end
         if (drop) begin
            rm_ff <= rm_ff + CW'(1);
         end
         if (key_eq && !match_ff) begin
            match_ff        <= 1'b1;
            match_idx_ff    <= smp_idx;
            match_size_ff   <= smp_data.size;
            match_handle_ff <= smp_data.handle;
         end
         if (!smp_data.valid && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= smp_idx;
         end
         if (smp_data.valid && !key_eq && (!old_ff || smp_data.stamp < old_stamp_ff)) begin
            old_ff       <= 1'b1;
            old_idx_ff   <= smp_idx;
            old_stamp_ff <= smp_data.stamp;
            old_addr_ff  <= smp_data.address;
         end
      end
   end

   assign valid_cnt      = cnt_ff;
   assign removed_cnt    = rm_ff;
   assign match          = match_ff;
   assign match_idx      = match_idx_ff;
   assign match_size     = match_size_ff;
   assign match_handle   = match_handle_ff;
   assign free           = free_ff;
   assign free_idx       = free_idx_ff;
   assign oldest         = old_ff;
   assign oldest_idx     = old_idx_ff;
   assign oldest_address = old_addr_ff;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
   import tblru_pkg::*;

   localparam int ENTRIES = 64;
   localparam int NO_WRITE = -1;
   localparam int CYCLE_LIMIT = 600000;
   localparam int POOL_KEYS = 96;
   localparam int PHASES = 9;
   localparam int IDLE_PERCENT = 11;

   typedef struct packed {
      opcode_type  op;
      logic [31:0] addr;
      logic [31:0] bsize;
      logic [31:0] handle;
      logic [31:0] len;
   } table_op_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] size;
      logic [31:0] handle;
      logic        evicted;
      logic [31:0] ev_addr;
      logic [6:0]  removed;
   } table_result_type;

   typedef struct packed {
      int               limit_write;
      table_op_type     op;
      logic             has_literal;
      table_result_type literal;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_opcode = 2'd0;
   logic [31:0] req_address = 32'h0;
   logic [31:0] req_block_size = 32'h0;
   logic [31:0] req_entry_handle = 32'h0;
   logic [31:0] req_range_length = 32'h0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_hit;
   logic [31:0] rsp_found_size;
   logic [31:0] rsp_found_handle;
   logic        rsp_evicted;
   logic [31:0] rsp_evicted_address;
   logic [6:0]  rsp_removed_count;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'h0;
   logic [31:0] prdata;
   logic        pready;

   // table shadow
   logic        slot_valid [ENTRIES];
   logic [31:0] slot_addr [ENTRIES];
   logic [31:0] slot_size [ENTRIES];
   logic [31:0] slot_handle [ENTRIES];
   logic [63:0] slot_stamp [ENTRIES];
   logic [63:0] use_count = 64'd0;
   logic [6:0]  limit_reg = MAX_ENTRIES_RESET;

   table_result_type pending_results [$];
   directed_row_type dir_rows [$];
   logic [31:0]      key_pool [POOL_KEYS];
   bit               lit_pending = 1'b0;
   table_result_type lit_result = '0;
   bit               quiet_run = 1'b0;
   int               error_count = 0;
   int               cycle_count = 0;

   translated_block_lru_table_core #(.ENTRIES(ENTRIES)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_opcode(req_opcode),
      .req_address(req_address),
      .req_block_size(req_block_size),
      .req_entry_handle(req_entry_handle),
      .req_range_length(req_range_length),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_hit(rsp_hit),
      .rsp_found_size(rsp_found_size),
      .rsp_found_handle(rsp_found_handle),
      .rsp_evicted(rsp_evicted),
      .rsp_evicted_address(rsp_evicted_address),
      .rsp_removed_count(rsp_removed_count),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached", $time);
         $display("tb: failure");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_ready <= quiet_run || ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   function automatic int oldest_slot(int skip);
      int best;
      best = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_valid[i] && i != skip) begin
            if (best < 0 || slot_stamp[i] < slot_stamp[best]) best = i;
         end
      end
      return best;
   endfunction

   function automatic table_result_type compute_table_result(table_op_type t);
      table_result_type r;
      int               eff;
      int               count;
      int               slot;
      int               victim;
      int               gone;
      logic [31:0]      range_end;
      r = '0;
      eff = (limit_reg == 7'd0) ? 1 : ((int'(limit_reg) > ENTRIES) ? ENTRIES : int'(limit_reg));
      count = 0;
      slot = -1;
      gone = 0;
      victim = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_valid[i]) begin
            count++;
            if (slot < 0 && slot_addr[i] == t.addr) slot = i;
         end
      end
      case (t.op)
         OP_LOOKUP: begin
            if (slot >= 0) begin
               use_count = use_count + 64'd1;
               slot_stamp[slot] = use_count;
               r.hit = 1'b1;
               r.size = slot_size[slot];
               r.handle = slot_handle[slot];
            end
         end
         OP_INSERT: begin
            use_count = use_count + 64'd1;
            if (slot >= 0) begin
               r.hit = 1'b1;
               if (count > eff) victim = oldest_slot(slot);
            end else if (count + 1 > eff) begin
               victim = oldest_slot(-1);
            end
            if (victim >= 0) begin
               r.evicted = 1'b1;
               r.ev_addr = slot_addr[victim];
               slot_valid[victim] = 1'b0;
            end
            if (slot < 0) begin
               for (int i = ENTRIES - 1; i >= 0; i--) begin
                  if (!slot_valid[i]) slot = i;
               end
            end
            if (slot >= 0) begin
               slot_valid[slot] = 1'b1;
               slot_addr[slot] = t.addr;
               slot_size[slot] = t.bsize;
               slot_handle[slot] = t.handle;
               slot_stamp[slot] = use_count;
            end
            r.size = t.bsize;
            r.handle = t.handle;
         end
         OP_INVAL_RANGE: begin
            if (t.len != 32'h0) begin
               range_end = t.addr + t.len;
               for (int i = 0; i < ENTRIES; i++) begin
                  if (slot_valid[i] && slot_addr[i] >= t.addr && slot_addr[i] < range_end) begin
                     slot_valid[i] = 1'b0;
                     gone++;
                  end
               end
            end
            r.removed = 7'(gone);
         end
         default: begin
            r.removed = 7'(count);
            for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 1'b0;
         end
      endcase
      return r;
   endfunction

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      table_result_type want;
      table_result_type predicted;
      if (!reset && req_valid && req_ready) begin
         predicted = compute_table_result('{opcode_type'(req_opcode), req_address,
                                            req_block_size, req_entry_handle,
                                            req_range_length});
         pending_results.insert(pending_results.size(),
                                lit_pending ? lit_result : predicted);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result transfer with nothing expected", $time);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("hit", 32'(want.hit), 32'(rsp_hit));
            check_field("found_size", want.size, rsp_found_size);
            check_field("found_handle", want.handle, rsp_found_handle);
            check_field("evicted", 32'(want.evicted), 32'(rsp_evicted));
            check_field("evicted_address", want.ev_addr, rsp_evicted_address);
            check_field("removed_count", 32'(want.removed), 32'(rsp_removed_count));
         end
      end
   end

   // hold the payload until the transfer; valid stays high on return
   task automatic send_item(input table_op_type t, input bit lit,
                            input table_result_type lr);
      @(negedge clock);
      lit_pending = lit;
      lit_result = lr;
      req_valid <= 1'b1;
      req_opcode <= t.op;
      req_address <= t.addr;
      req_block_size <= t.bsize;
      req_entry_handle <= t.handle;
      req_range_length <= t.len;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic add_row(input directed_row_type row);
      dir_rows.insert(dir_rows.size(), row);
   endtask

   task automatic csr_cycle(input bit is_write, input logic [6:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= is_write;
      paddr <= 3'(4 * CSR_MAX_ENTRIES);
      pwdata <= {25'($urandom()), value};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (is_write) limit_reg = value;
      else check_field("max_entries readback", {25'h0, limit_reg}, prdata);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   function automatic table_op_type random_table_op(int pool_n);
      table_op_type t;
      int           pick;
      logic [31:0]  key;
      pick = $urandom_range(0, 99);
      key = key_pool[$urandom_range(0, pool_n - 1)];
      t.op = (pick < 42) ? OP_LOOKUP : (pick < 84) ? OP_INSERT :
             (pick < 97) ? OP_INVAL_RANGE : OP_INVAL_ALL;
      t.addr = ($urandom_range(0, 99) < 88) ? key : $urandom();
      t.bsize = $urandom();
      t.handle = $urandom();
      t.len = $urandom();
      if (t.op == OP_INVAL_RANGE) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            t.addr = key;
            t.len = 32'h0;
         end else if (pick < 16) begin
            // end wraps round past zero
            t.addr = key;
            t.len = (~key) + 32'd1 + 32'($urandom_range(0, 1000));
         end else if (pick < 80) begin
            t.addr = key - 32'($urandom_range(0, 24));
            t.len = 32'($urandom_range(1, 64));
         end
      end
      return t;
   endfunction

   initial begin
      int           phase_limit [PHASES];
      int           phase_items [PHASES];
      int           phase_pool [PHASES];
      int           items_sent;
      logic [31:0]  key_base;
      table_op_type t;

      phase_limit = '{1, 64, 5, 0, 127, 16, 3, 40, 2};
      phase_items = '{60, 240, 60, 40, 70, 80, 50, 100, 50};
      phase_pool = '{8, 96, 12, 6, 40, 24, 8, 60, 6};
      phase_limit[7] = $urandom_range(6, 63);
      items_sent = 0;
      for (int i = 0; i < ENTRIES; i++) begin
         slot_valid[i] = 1'b0;
         slot_addr[i] = 32'h0;
         slot_size[i] = 32'h0;
         slot_handle[i] = 32'h0;
         slot_stamp[i] = 64'd0;
      end
      key_base = $urandom() & 32'hFFFF_FFF0;
      for (int i = 0; i < POOL_KEYS; i++) key_pool[i] = key_base + 32'(i * 16);
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;

      add_row('{NO_WRITE, '{OP_LOOKUP, 32'h0, 32'h0, 32'h0, 32'h0},
                1'b1, '{1'b0, 32'h0, 32'h0, 1'b0, 32'h0, 7'd0}});
      add_row('{NO_WRITE, '{OP_INVAL_ALL, 32'h0, 32'h0, 32'h0, 32'h0},
                1'b1, '{1'b0, 32'h0, 32'h0, 1'b0, 32'h0, 7'd0}});
      add_row('{NO_WRITE, '{OP_INVAL_RANGE, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF},
                1'b1, '{1'b0, 32'h0, 32'h0, 1'b0, 32'h0, 7'd0}});
      add_row('{NO_WRITE, '{OP_INSERT, 32'h0, 32'h0, 32'h0, 32'h0},
                1'b1, '{1'b0, 32'h0, 32'h0, 1'b0, 32'h0, 7'd0}});
      add_row('{NO_WRITE, '{OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, 32'h0},
                1'b1, '{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 7'd0}});
      add_row('{NO_WRITE, '{OP_INSERT, 32'h1000, 32'h40, 32'hA5A5_A5A5, 32'h0},
                1'b1, '{1'b0, 32'h40, 32'hA5A5_A5A5, 1'b0, 32'h0, 7'd0}});
      add_row('{NO_WRITE, '{OP_LOOKUP, 32'h1000, 32'h0, 32'h0, 32'h0}, 1'b0, '0});
      add_row('{NO_WRITE, '{OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0},
                1'b0, '0});
      add_row('{NO_WRITE, '{OP_INSERT, 32'h1000, 32'h80, 32'h5A5A_5A5A, 32'h0},
                1'b0, '0});
      add_row('{NO_WRITE, '{OP_LOOKUP, 32'h1004, 32'h0, 32'h0, 32'h0},
                1'b1, '{1'b0, 32'h0, 32'h0, 1'b0, 32'h0, 7'd0}});
      add_row('{NO_WRITE, '{OP_INVAL_RANGE, 32'h1000, 32'h0, 32'h0, 32'h0},
                1'b1, '{1'b0, 32'h0, 32'h0, 1'b0, 32'h0, 7'd0}});
      add_row('{NO_WRITE, '{OP_INVAL_RANGE, 32'hFFFF_FFF0, 32'h0, 32'h0, 32'h20},
                1'b1, '{1'b0, 32'h0, 32'h0, 1'b0, 32'h0, 7'd0}});
      add_row('{NO_WRITE, '{OP_INVAL_RANGE, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h1},
                1'b1, '{1'b0, 32'h0, 32'h0, 1'b0, 32'h0, 7'd0}});
      add_row('{NO_WRITE, '{OP_INVAL_RANGE, 32'hFFFF_FFFE, 32'h0, 32'h0, 32'h1},
                1'b1, '{1'b0, 32'h0, 32'h0, 1'b0, 32'h0, 7'd0}});
      add_row('{NO_WRITE, '{OP_INVAL_RANGE, 32'h1000, 32'h0, 32'h0, 32'h1},
                1'b0, '0});
      add_row('{NO_WRITE, '{OP_LOOKUP, 32'h1000, 32'h0, 32'h0, 32'h0}, 1'b0, '0});
      add_row('{NO_WRITE, '{OP_INVAL_RANGE, 32'h0, 32'h0, 32'h0, 32'h8000_0000},
                1'b0, '0});
      add_row('{NO_WRITE, '{OP_INVAL_ALL, 32'h0, 32'h0, 32'h0, 32'h0}, 1'b0, '0});
      add_row('{2, '{OP_INSERT, 32'h100, 32'h1111_1111, 32'h2222_2222, 32'h0},
                1'b0, '0});
      add_row('{NO_WRITE, '{OP_INSERT, 32'h200, 32'h3333_3333, 32'h4444_4444,
                             32'h0}, 1'b0, '0});
      add_row('{NO_WRITE, '{OP_INSERT, 32'h300, 32'h5555_5555, 32'h6666_6666,
                             32'h0}, 1'b0, '0});
      add_row('{NO_WRITE, '{OP_LOOKUP, 32'h200, 32'h0, 32'h0, 32'h0}, 1'b0, '0});
      add_row('{NO_WRITE, '{OP_INSERT, 32'h400, 32'h7777_7777, 32'h8888_8888,
                             32'h0}, 1'b0, '0});
      add_row('{0, '{OP_INSERT, 32'h200, 32'h9999_9999, 32'hAAAA_AAAA, 32'h0},
                1'b0, '0});
      add_row('{127, '{OP_INSERT, 32'h500, 32'hBBBB_BBBB, 32'hCCCC_CCCC, 32'h0},
                1'b0, '0});

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      csr_cycle(1'b0, 7'd0);

      foreach (dir_rows[r]) begin
         if (dir_rows[r].limit_write != NO_WRITE) begin
            drain();
            csr_cycle(1'b1, 7'(dir_rows[r].limit_write));
            csr_cycle(1'b0, 7'd0);
         end
         send_item(dir_rows[r].op, dir_rows[r].has_literal, dir_rows[r].literal);
      end

      for (int p = 0; p < PHASES; p++) begin
         drain();
         csr_cycle(1'b1, 7'(phase_limit[p]));
         csr_cycle(1'b0, 7'd0);
         for (int n = 0; n < phase_items[p]; n++) begin
            quiet_run = (items_sent >= 300 && items_sent < 420);
            if (!quiet_run && $urandom_range(0, 99) < IDLE_PERCENT) begin
               @(negedge clock);
               req_valid <= 1'b0;
               repeat ($urandom_range(0, 79)) @(negedge clock);
            end
            t = random_table_op(phase_pool[p]);
            send_item(t, 1'b0, '0);
            items_sent++;
         end
      end
      quiet_run = 1'b0;

      drain();
      repeat (ENTRIES + 16) @(posedge clock);
      if (pending_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, pending_results.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/tblru_pkg.sv
hw/rtl/tblru_mem.sv
hw/rtl/tblru_scan.sv
hw/rtl/translated_block_lru_table_core.sv
tb/tb_top.sv
